// ===== rtl/mmr_pkg.sv =====
// Shared types and constants for the diverse selector.
// Used by the controller, the datapath, the cosine unit, the top level and the testbench; no dependencies.
package mmr_pkg;

    // Input item operations.
    localparam logic [1:0] OP_LOAD_QUERY = 2'd0;
    localparam logic [1:0] OP_LOAD_CAND  = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WEIGHT    = 2'd0;
    localparam logic [1:0] CFG_MAX_PICKS = 2'd1;
    localparam logic [1:0] CFG_VEC_LEN   = 2'd2;

    // Register reset values.
    localparam logic [15:0] WEIGHT_RESET    = 16'd16384;
    localparam logic [5:0]  MAX_PICKS_RESET = 6'd8;
    localparam logic [6:0]  VEC_LEN_RESET   = 7'd64;

    // Q1.15 and Q0.15 constants.
    localparam logic [16:0]        W_ONE   = 17'd32768;
    localparam logic signed [15:0] Q15_MAX = 16'sd32767;
    localparam logic signed [15:0] Q15_MIN = -16'sd32768;
    localparam logic signed [15:0] Q15_ZERO = 16'sd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic start_run;
        logic cos_start;
        logic cos_pen;
        logic rel_upd;
        logic pen_upd;
        logic mul1;
        logic mul2;
        logic cmp;
        logic i_inc;
        logic emit_empty;
        logic emit_zw;
        logic emit_first;
        logic emit_pick;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_req;
        logic count_zero;
        logic w_zero;
        logic i_last;
        logic p_last;
        logic chosen_i;
        logic cos_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/mmr_diverse_selector_top.sv =====
// Top level of the diverse selector: joins the run sequencer and the datapath.
// Depends on mmr_pkg, mmr_ctrl and mmr_dp (with mmr_cos and mmr_ram below it).
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    operation, slots, value, count
//   out       output     o_out_valid / i_out_stall  pick_slot, pick_score, flags
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load request is taken while the sequencer is idle. A run request holds
// o_in_stall high for its whole selection walk; each similarity goes through
// start, element walk, drain, 19-step square roots side by side, multiply,
// divide setup, an 18-step divide and a finish step in the single cosine unit.
// A run with a nonzero weight takes one similarity per candidate for relevance
// plus one per unpicked candidate per later pick; each result may wait on i_out_stall.
// Reset is synchronous; the vector stores are not cleared.
// Each result waits in the output register while the walk continues.
module mmr_diverse_selector_top #(
    parameter int MAX_DIM        = 64,
    parameter int MAX_CANDIDATES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_operation,
    input  logic [4:0]          i_candidate_slot,
    input  logic [5:0]          i_element_slot,
    input  logic signed [15:0]  i_element_value,
    input  logic [5:0]          i_candidate_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [4:0]          o_pick_slot,
    output logic signed [15:0]  o_pick_score,
    output logic                o_last_pick,
    output logic                o_empty_set
);

    mmr_pkg::t_cmd  cmd;
    mmr_pkg::t_stat stat;

    mmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mmr_dp #(.MAX_DIM(MAX_DIM), .MAX_CANDIDATES(MAX_CANDIDATES)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_in_valid        (i_in_valid),
        .i_operation       (i_operation),
        .i_candidate_slot  (i_candidate_slot),
        .i_element_slot    (i_element_slot),
        .i_element_value   (i_element_value),
        .i_candidate_count (i_candidate_count),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pick_slot       (o_pick_slot),
        .o_pick_score      (o_pick_score),
        .o_last_pick       (o_last_pick),
        .o_empty_set       (o_empty_set)
    );

    assign o_in_stall  = !cmd.idle;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/mmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mmr_cos.sv =====
// Iterative cosine similarity unit: element walk with exact accumulation,
// digit-by-digit square roots, one multiply and a bit-serial divide.
// Depends on mmr_pkg; the caller supplies element pairs in the cycle after o_elem.
module mmr_cos #(
    parameter int MAX_DIM = 64,
    localparam int LW    = $clog2(MAX_DIM + 1),
    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [LW-1:0]       i_len,
    output logic [DIM_W-1:0]    o_elem,
    input  logic signed [15:0]  i_a,
    input  logic signed [15:0]  i_b,
    output logic                o_done,
    output logic signed [15:0]  o_sim
);

    localparam int ACC_W  = 32 + LW;
    localparam int NW     = 31 + LW;
    localparam int NW2    = NW + (NW % 2);
    localparam int SQ_W   = NW2 / 2;
    localparam int KW     = $clog2(SQ_W + 1);
    localparam int DEN_W  = 2 * SQ_W;
    localparam int NUM_W  = ACC_W + 15;
    localparam int DSH_W  = DEN_W + 18;
    localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;

    localparam logic signed [15:0] Q15_MAX_L = mmr_pkg::Q15_MAX;
    localparam logic signed [15:0] Q15_MIN_L = mmr_pkg::Q15_MIN;

    typedef enum logic [7:0] {
        C_IDLE  = 8'b00000001,
        C_WALK  = 8'b00000010,
        C_DRAIN = 8'b00000100,
        C_ROOT  = 8'b00001000,
        C_MULT  = 8'b00010000,
        C_PREP  = 8'b00100000,
        C_DIV   = 8'b01000000,
        C_DONE  = 8'b10000000
    } t_cos_state;

    t_cos_state               r_state;
    logic [LW-1:0]            r_len;
    logic [LW-1:0]            r_e;
    logic                     r_v1;
    logic                     r_v2;
    logic signed [31:0]       r_pxy;
    logic signed [31:0]       r_paa;
    logic signed [31:0]       r_pbb;
    logic signed [ACC_W-1:0]  r_dot;
    logic [NW2-1:0]           r_na;
    logic [NW2-1:0]           r_nb;
    logic [SQ_W-1:0]          r_ra;
    logic [SQ_W-1:0]          r_rb;
    logic [SQ_W+1:0]          r_rema;
    logic [SQ_W+1:0]          r_remb;
    logic [KW-1:0]            r_k;
    logic [DEN_W-1:0]         r_den;
    logic                     r_neg;
    logic [CMP_W-1:0]         r_num;
    logic [CMP_W-1:0]         r_dsh;
    logic [17:0]              r_quo;
    logic [4:0]               r_qk;

    logic [2*SQ_W+1:0]        n_step_a;
    logic [2*SQ_W+1:0]        n_step_b;
    logic [ACC_W-1:0]         n_mag;

    // One step of the restoring square root: bring down two bits, try 4r+1.
    function automatic logic [2*SQ_W+1:0] root_step(input logic [SQ_W+1:0] rem,
                                                     input logic [SQ_W-1:0] r,
                                                     input logic [1:0] bits);
        logic [SQ_W+1:0] rs;
        logic [SQ_W+1:0] tr;
        rs = {rem[SQ_W-1:0], bits};
        tr = {r, 2'b01};
        if (rs >= tr) begin
            root_step = {rs - tr, r[SQ_W-2:0], 1'b1};
        end else begin
            root_step = {rs, r[SQ_W-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        n_step_a = root_step(r_rema, r_ra, r_na[NW2-1 -: 2]);
        n_step_b = root_step(r_remb, r_rb, r_nb[NW2-1 -: 2]);
        n_mag    = r_dot[ACC_W-1] ? ACC_W'(-r_dot) : ACC_W'(r_dot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= (r_state == C_WALK);
            r_v2 <= r_v1;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_len == '0) ? C_DRAIN : C_WALK;
                    end
                end
                C_WALK: begin
                    if (r_e + LW'(1) == r_len) begin
                        r_state <= C_DRAIN;
                    end
                end
                C_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= C_ROOT;
                    end
                end
                C_ROOT: begin
                    if (r_k == KW'(SQ_W - 1)) begin
                        r_state <= C_MULT;
                    end
                end
                C_MULT: r_state <= C_PREP;
                C_PREP: r_state <= (r_den == '0) ? C_DONE : C_DIV;
                C_DIV: begin
                    if (r_qk == 5'd17) begin
                        r_state <= C_DONE;
                    end
                end
                C_DONE:  r_state <= C_IDLE;
                default: r_state <= C_IDLE;
            endcase
        end
    end

    // Datapath registers of the unit.
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_len <= i_len;
            r_e   <= '0;
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else begin
            if (r_state == C_WALK) begin
                r_e <= r_e + LW'(1);
            end
            if (r_v2) begin
                r_dot <= r_dot + {{(ACC_W-32){r_pxy[31]}}, r_pxy};
                r_na  <= r_na + {{(NW2-31){1'b0}}, r_paa[30:0]};
                r_nb  <= r_nb + {{(NW2-31){1'b0}}, r_pbb[30:0]};
            end else if (r_state == C_ROOT) begin
                r_na <= r_na << 2;
                r_nb <= r_nb << 2;
            end
        end
        if (r_v1) begin
            r_pxy <= i_a * i_b;
            r_paa <= i_a * i_a;
            r_pbb <= i_b * i_b;
        end
        if (r_state == C_DRAIN) begin
            r_ra   <= '0;
            r_rb   <= '0;
            r_rema <= '0;
            r_remb <= '0;
            r_k    <= '0;
        end else if (r_state == C_ROOT) begin
            r_rema <= n_step_a[2*SQ_W+1 -: SQ_W+2];
            r_ra   <= n_step_a[SQ_W-1:0];
            r_remb <= n_step_b[2*SQ_W+1 -: SQ_W+2];
            r_rb   <= n_step_b[SQ_W-1:0];
            r_k    <= r_k + KW'(1);
        end
        if (r_state == C_MULT) begin
            r_den <= r_ra * r_rb;
            r_neg <= r_dot[ACC_W-1];
            r_num <= CMP_W'(n_mag) << 15;
        end
        if (r_state == C_PREP) begin
            r_dsh <= CMP_W'(r_den) << 17;
            r_quo <= '0;
            r_qk  <= '0;
            if (r_den == '0) begin
                r_neg <= 1'b0;
            end
        end else if (r_state == C_DIV) begin
            if (r_num >= r_dsh) begin
                r_num <= r_num - r_dsh;
                r_quo <= {r_quo[16:0], 1'b1};
            end else begin
                r_quo <= {r_quo[16:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
            r_qk  <= r_qk + 5'd1;
        end
    end

    // Sign and clamp to Q1.15; the quotient is truncated toward zero.
    always_comb begin
        if (r_neg) begin
            o_sim = (r_quo > 18'd32768) ? Q15_MIN_L : 16'(-$signed({1'b0, r_quo}));
        end else begin
            o_sim = (r_quo > 18'd32767) ? Q15_MAX_L : $signed(r_quo[15:0]);
        end
    end

    assign o_elem = r_e[DIM_W-1:0];
    assign o_done = (r_state == C_DONE);

endmodule

// ===== rtl/mmr_dp.sv =====
// Datapath of the diverse selector: configuration registers, vector stores,
// relevance and penalty tables, score arithmetic and the output register.
// Depends on mmr_pkg, mmr_ram and mmr_cos.
module mmr_dp #(
    parameter int MAX_DIM        = 64,
    parameter int MAX_CANDIDATES = 32,
    localparam int LW    = $clog2(MAX_DIM + 1),
    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
    localparam int CW    = $clog2(MAX_CANDIDATES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmr_pkg::t_cmd       i_cmd,
    output mmr_pkg::t_stat      o_stat,
    input  logic                i_in_valid,
    input  logic [1:0]          i_operation,
    input  logic [4:0]          i_candidate_slot,
    input  logic [5:0]          i_element_slot,
    input  logic signed [15:0]  i_element_value,
    input  logic [5:0]          i_candidate_count,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [4:0]          o_pick_slot,
    output logic signed [15:0]  o_pick_score,
    output logic                o_last_pick,
    output logic                o_empty_set
);

    localparam int CA_W = IDX_W + DIM_W;

    logic [15:0]               r_weight;
    logic [5:0]                r_max_picks;
    logic [6:0]                r_vec_len;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_n;
    logic [16:0]               r_w;
    logic [LW-1:0]             r_len;
    logic [IDX_W-1:0]          r_i;
    logic [IDX_W-1:0]          r_p;
    logic [IDX_W-1:0]          r_best_slot;
    logic [IDX_W-1:0]          r_last_slot;
    logic signed [15:0]        r_best_rel;
    logic signed [33:0]        r_best_s;
    logic                      r_found;
    logic                      r_mode_pen;
    logic [MAX_CANDIDATES-1:0] r_chosen;
    logic signed [15:0]        r_rel [MAX_CANDIDATES];
    logic signed [15:0]        r_pen [MAX_CANDIDATES];
    logic signed [33:0]        r_prod1;
    logic signed [33:0]        r_prod2;

    logic                      r_out_valid;
    logic [4:0]                r_out_slot;
    logic signed [15:0]        r_out_score;
    logic                      r_out_last;
    logic                      r_out_empty;

    logic [CW-1:0]             n_count;
    logic [CW-1:0]             n_n;
    logic [CW-1:0]             n_k;
    logic [16:0]               n_w;
    logic [LW-1:0]             n_len;
    logic [16:0]               n_wc;
    logic signed [15:0]        n_newpen;
    logic signed [33:0]        n_s;
    logic signed [18:0]        n_sh;
    logic signed [15:0]        n_sat;
    logic                      n_load_ok;
    logic                      n_q_we;
    logic                      n_c_we;
    logic                      n_out_free;

    logic [DIM_W-1:0]          cos_elem;
    logic signed [15:0]        cos_sim;
    logic                      cos_done;
    logic [15:0]               q_rdata;
    logic [15:0]               ca_rdata;
    logic [15:0]               cb_rdata;
    logic signed [15:0]        cos_a;
    logic signed [15:0]        cos_b;

    // Saturated run settings, taken when the run request is accepted.
    always_comb begin
        n_count = (32'(i_candidate_count) > MAX_CANDIDATES) ? CW'(MAX_CANDIDATES)
                                                            : CW'(i_candidate_count);
        if (r_max_picks == '0) begin
            n_k = CW'(1);
        end else if (32'(r_max_picks) > MAX_CANDIDATES) begin
            n_k = CW'(MAX_CANDIDATES);
        end else begin
            n_k = CW'(r_max_picks);
        end
        n_n   = (n_k < n_count) ? n_k : n_count;
        n_w   = (r_weight > 16'd32768) ? mmr_pkg::W_ONE : {1'b0, r_weight};
        n_len = (32'(r_vec_len) > MAX_DIM) ? LW'(MAX_DIM) : LW'(r_vec_len);
    end

    always_comb begin
        n_wc     = mmr_pkg::W_ONE - r_w;
        n_newpen = (cos_sim > r_pen[r_i]) ? cos_sim : r_pen[r_i];
        n_s      = r_prod1 - r_prod2;
        n_sh     = r_best_s[33:15];
        if (n_sh > 19'sd32767) begin
            n_sat = mmr_pkg::Q15_MAX;
        end else if (n_sh < -19'sd32768) begin
            n_sat = mmr_pkg::Q15_MIN;
        end else begin
            n_sat = n_sh[15:0];
        end
        n_out_free = !r_out_valid || !i_out_stall;
    end

    // Loads are taken only while the controller is idle.
    always_comb begin
        n_load_ok = i_cmd.idle && i_in_valid && (32'(i_element_slot) < MAX_DIM);
        n_q_we    = n_load_ok && (i_operation == mmr_pkg::OP_LOAD_QUERY);
        n_c_we    = n_load_ok && (i_operation == mmr_pkg::OP_LOAD_CAND)
                    && (32'(i_candidate_slot) < MAX_CANDIDATES);
    end

    mmr_ram #(.WIDTH(16), .DEPTH(2 ** DIM_W)) u_query (
        .i_clk   (i_clk),
        .i_we    (n_q_we),
        .i_waddr (DIM_W'(i_element_slot)),
        .i_wdata (i_element_value),
        .i_raddr (cos_elem),
        .o_rdata (q_rdata)
    );

    // The candidate store is held twice so that two vectors read in parallel.
    mmr_ram #(.WIDTH(16), .DEPTH(2 ** CA_W)) u_cand_a (
        .i_clk   (i_clk),
        .i_we    (n_c_we),
        .i_waddr ({IDX_W'(i_candidate_slot), DIM_W'(i_element_slot)}),
        .i_wdata (i_element_value),
        .i_raddr ({r_i, cos_elem}),
        .o_rdata (ca_rdata)
    );

    mmr_ram #(.WIDTH(16), .DEPTH(2 ** CA_W)) u_cand_b (
        .i_clk   (i_clk),
        .i_we    (n_c_we),
        .i_waddr ({IDX_W'(i_candidate_slot), DIM_W'(i_element_slot)}),
        .i_wdata (i_element_value),
        .i_raddr ({r_last_slot, cos_elem}),
        .o_rdata (cb_rdata)
    );

    assign cos_a = r_mode_pen ? $signed(ca_rdata) : $signed(q_rdata);
    assign cos_b = r_mode_pen ? $signed(cb_rdata) : $signed(ca_rdata);

    mmr_cos #(.MAX_DIM(MAX_DIM)) u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cos_start),
        .i_len   (r_len),
        .o_elem  (cos_elem),
        .i_a     (cos_a),
        .i_b     (cos_b),
        .o_done  (cos_done),
        .o_sim   (cos_sim)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= mmr_pkg::WEIGHT_RESET;
            r_max_picks <= mmr_pkg::MAX_PICKS_RESET;
            r_vec_len   <= mmr_pkg::VEC_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mmr_pkg::CFG_WEIGHT:    r_weight    <= i_cfg_data;
                mmr_pkg::CFG_MAX_PICKS: r_max_picks <= i_cfg_data[5:0];
                mmr_pkg::CFG_VEC_LEN:   r_vec_len   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Selection state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen <= '0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.start_run) begin
                r_count     <= n_count;
                r_n         <= n_n;
                r_w         <= n_w;
                r_len       <= n_len;
                r_i         <= '0;
                r_p         <= '0;
                r_best_rel  <= mmr_pkg::Q15_MIN;
                r_best_slot <= '0;
                r_found     <= 1'b0;
                r_chosen    <= '0;
                for (int c = 0; c < MAX_CANDIDATES; c++) begin
                    r_pen[c] <= mmr_pkg::Q15_ZERO;
                end
            end
            if (i_cmd.cos_start) begin
                r_mode_pen <= i_cmd.cos_pen;
            end
            if (i_cmd.rel_upd) begin
                r_rel[r_i] <= cos_sim;
                if (cos_sim > r_best_rel) begin
                    r_best_rel  <= cos_sim;
                    r_best_slot <= r_i;
                end
            end
            if (i_cmd.pen_upd) begin
                r_pen[r_i] <= n_newpen;
            end
            if (i_cmd.mul1) begin
                r_prod1 <= $signed({1'b0, r_w}) * r_rel[r_i];
            end
            if (i_cmd.mul2) begin
                r_prod2 <= $signed({1'b0, n_wc}) * r_pen[r_i];
            end
            if (i_cmd.cmp) begin
                if (!r_found || n_s > r_best_s) begin
                    r_found     <= 1'b1;
                    r_best_s    <= n_s;
                    r_best_slot <= r_i;
                end
            end
            if (i_cmd.i_inc) begin
                r_i <= r_i + IDX_W'(1);
            end
            if (i_cmd.emit_zw) begin
                r_p <= r_p + IDX_W'(1);
            end
            if (i_cmd.emit_first || i_cmd.emit_pick) begin
                r_chosen[r_best_slot] <= 1'b1;
                r_last_slot <= r_best_slot;
                r_p         <= r_p + IDX_W'(1);
                r_i         <= '0;
                r_found     <= 1'b0;
            end
        end
    end

    // Output register: a result waits here while the next work goes on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_empty || i_cmd.emit_zw || i_cmd.emit_first
                    || i_cmd.emit_pick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.emit_empty) begin
            r_out_slot  <= '0;
            r_out_score <= mmr_pkg::Q15_ZERO;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end else if (i_cmd.emit_zw) begin
            r_out_slot  <= 5'(r_p);
            r_out_score <= mmr_pkg::Q15_MAX;
            r_out_last  <= o_stat.p_last;
            r_out_empty <= 1'b0;
        end else if (i_cmd.emit_first) begin
            r_out_slot  <= 5'(r_best_slot);
            r_out_score <= r_best_rel;
            r_out_last  <= o_stat.p_last;
            r_out_empty <= 1'b0;
        end else if (i_cmd.emit_pick) begin
            r_out_slot  <= 5'(r_best_slot);
            r_out_score <= n_sat;
            r_out_last  <= o_stat.p_last;
            r_out_empty <= 1'b0;
        end
    end

    always_comb begin
        o_stat.run_req    = i_in_valid && (i_operation == mmr_pkg::OP_RUN);
        o_stat.count_zero = (r_count == '0);
        o_stat.w_zero     = (r_w == '0);
        o_stat.i_last     = (CW'(r_i) + CW'(1)) == r_count;
        o_stat.p_last     = (CW'(r_p) + CW'(1)) == r_n;
        o_stat.chosen_i   = r_chosen[r_i];
        o_stat.cos_done   = cos_done;
        o_stat.out_free   = n_out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pick_slot  = r_out_slot;
    assign o_pick_score = r_out_score;
    assign o_last_pick  = r_out_last;
    assign o_empty_set  = r_out_empty;

endmodule

// ===== rtl/mmr_ctrl.sv =====
// Run sequencer of the diverse selector: walks the relevance pass and the
// penalty rounds and issues commands to the datapath. Depends on mmr_pkg.
module mmr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mmr_pkg::t_stat  i_stat,
    output mmr_pkg::t_cmd   o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CHECK    = 14'b00000000000010,
        S_EMPTY    = 14'b00000000000100,
        S_ZW       = 14'b00000000001000,
        S_REL_GO   = 14'b00000000010000,
        S_REL_WAIT = 14'b00000000100000,
        S_REL_OUT  = 14'b00000001000000,
        S_PEN_SCAN = 14'b00000010000000,
        S_PEN_GO   = 14'b00000100000000,
        S_PEN_WAIT = 14'b00001000000000,
        S_PEN_M1   = 14'b00010000000000,
        S_PEN_M2   = 14'b00100000000000,
        S_PEN_CMP  = 14'b01000000000000,
        S_PEN_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_stat.run_req) begin
                    o_cmd.start_run = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.count_zero) begin
                    n_state = S_EMPTY;
                end else if (i_stat.w_zero) begin
                    n_state = S_ZW;
                end else begin
                    n_state = S_REL_GO;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ZW: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_zw = 1'b1;
                    if (i_stat.p_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REL_GO: begin
                o_cmd.cos_start = 1'b1;
                n_state = S_REL_WAIT;
            end
            S_REL_WAIT: begin
                if (i_stat.cos_done) begin
                    o_cmd.rel_upd = 1'b1;
                    if (i_stat.i_last) begin
                        n_state = S_REL_OUT;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state = S_REL_GO;
                    end
                end
            end
            S_REL_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_first = 1'b1;
                    n_state = i_stat.p_last ? S_IDLE : S_PEN_SCAN;
                end
            end
            S_PEN_SCAN: begin
                // Candidates already picked are skipped without a similarity.
                if (i_stat.chosen_i) begin
                    if (i_stat.i_last) begin
                        n_state = S_PEN_OUT;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                    end
                end else begin
                    n_state = S_PEN_GO;
                end
            end
            S_PEN_GO: begin
                o_cmd.cos_start = 1'b1;
                o_cmd.cos_pen   = 1'b1;
                n_state = S_PEN_WAIT;
            end
            S_PEN_WAIT: begin
                if (i_stat.cos_done) begin
                    o_cmd.pen_upd = 1'b1;
                    n_state = S_PEN_M1;
                end
            end
            S_PEN_M1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_PEN_M2;
            end
            S_PEN_M2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_PEN_CMP;
            end
            S_PEN_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.i_last) begin
                    n_state = S_PEN_OUT;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state = S_PEN_SCAN;
                end
            end
            S_PEN_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_pick = 1'b1;
                    n_state = i_stat.p_last ? S_IDLE : S_PEN_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A result is only written into a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_empty || o_cmd.emit_zw || o_cmd.emit_first || o_cmd.emit_pick)
        |-> i_stat.out_free)
        else $error("result emitted into a full output register");

    // The cosine unit only finishes while the sequencer waits for it.
    a_cos_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.cos_done |-> (r_state == S_REL_WAIT || r_state == S_PEN_WAIT))
        else $error("similarity finished outside a wait state");

    // Picked candidates never get a penalty similarity.
    a_skip_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEN_GO) |-> !i_stat.chosen_i)
        else $error("penalty computed for a picked candidate");

    // After a similarity starts, the unit cannot be done in the next cycle.
    a_cos_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cos_start |=> !i_stat.cos_done)
        else $error("similarity done too early");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for mmr_diverse_selector_top: loads vectors, runs selections
// and compares every pick against a cycle-free predictor held in this file.
// Depends on mmr_pkg and the RTL of the selector.
module tb;

    localparam int NDIM = 64;
    localparam int NCAND = 32;
    localparam int PRE_DIM = 4;
    localparam int CYCLE_LIMIT = 20000000;

    typedef logic signed [15:0] t_vec [NDIM];

    typedef struct {
        logic [4:0]         slot;
        logic signed [15:0] score;
        logic               last;
        logic               empty;
    } t_pick;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_operation;
    logic [4:0]         i_candidate_slot;
    logic [5:0]         i_element_slot;
    logic signed [15:0] i_element_value;
    logic [5:0]         i_candidate_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [4:0]         o_pick_slot;
    logic signed [15:0] o_pick_score;
    logic               o_last_pick;
    logic               o_empty_set;

    // Shadow copy of the block's stores and registers.
    t_vec        query_mem;
    t_vec        cand_mem [NCAND];
    logic [15:0] weight_reg;
    logic [5:0]  picks_reg;
    logic [6:0]  vlen_reg;

    t_pick pending_picks[$];
    int    error_count;
    int    cycle_count;
    bit    quiet;

    mmr_diverse_selector_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_candidate_slot (i_candidate_slot),
        .i_element_slot   (i_element_slot),
        .i_element_value  (i_element_value),
        .i_candidate_count(i_candidate_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pick_slot      (o_pick_slot),
        .o_pick_score     (o_pick_score),
        .o_last_pick      (o_last_pick),
        .o_empty_set      (o_empty_set)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < 13);
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int cosine(input t_vec a, input t_vec b, input int len);
        longint          dot;
        longint unsigned na;
        longint unsigned nb;
        longint unsigned den;
        longint          q;
        dot = 0;
        na = 0;
        nb = 0;
        for (int i = 0; i < len; i++) begin
            dot += longint'(a[i]) * longint'(b[i]);
            na += longint'(a[i]) * longint'(a[i]);
            nb += longint'(b[i]) * longint'(b[i]);
        end
        den = int_sqrt(na) * int_sqrt(nb);
        if (den == 0) return 0;
        q = (dot * 32768) / longint'(den);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    // Floor division of a Q2.30 score down to Q1.15, then saturation.
    function automatic int score_q15(input longint s);
        longint q;
        if (s >= 0) q = s / 32768;
        else q = -((-s + 32767) / 32768);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic void push_pick(input int slot, input int score, input bit last,
                                      input bit empty);
        t_pick p;
        p.slot = slot[4:0];
        p.score = score[15:0];
        p.last = last;
        p.empty = empty;
        pending_picks = {pending_picks, p};
    endfunction

    function automatic void predict_selection(input int raw_count);
        int     count;
        int     k;
        int     w;
        int     len;
        int     n;
        int     rel [NCAND];
        bit     chosen [NCAND];
        int     order [NCAND];
        int     best;
        int     best_rel;
        int     pen;
        int     sim;
        int     bi;
        bit     found;
        longint sc;
        longint best_s;
        count = (raw_count > NCAND) ? NCAND : raw_count;
        k = picks_reg;
        if (k == 0) k = 1;
        if (k > NCAND) k = NCAND;
        w = (weight_reg > 32768) ? 32768 : weight_reg;
        len = (vlen_reg > NDIM) ? NDIM : vlen_reg;
        if (count == 0) begin
            push_pick(0, 0, 1'b1, 1'b1);
            return;
        end
        n = (k < count) ? k : count;
        if (w == 0) begin
            for (int i = 0; i < n; i++) push_pick(i, 32767, i + 1 == n, 1'b0);
            return;
        end
        for (int i = 0; i < NCAND; i++) chosen[i] = 1'b0;
        for (int i = 0; i < count; i++) rel[i] = cosine(query_mem, cand_mem[i], len);
        best_rel = -32768;
        best = 0;
        for (int i = 0; i < count; i++) begin
            if (rel[i] > best_rel) begin
                best_rel = rel[i];
                best = i;
            end
        end
        chosen[best] = 1'b1;
        order[0] = best;
        push_pick(best, best_rel, n == 1, 1'b0);
        for (int p = 1; p < n; p++) begin
            found = 1'b0;
            best_s = 0;
            bi = 0;
            for (int i = 0; i < count; i++) begin
                if (!chosen[i]) begin
                    pen = 0;
                    for (int j = 0; j < p; j++) begin
                        sim = cosine(cand_mem[i], cand_mem[order[j]], len);
                        if (sim > pen) pen = sim;
                    end
                    sc = longint'(w) * rel[i] - longint'(32768 - w) * pen;
                    if (!found || sc > best_s) begin
                        found = 1'b1;
                        best_s = sc;
                        bi = i;
                    end
                end
            end
            chosen[bi] = 1'b1;
            order[p] = bi;
            push_pick(bi, score_q15(best_s), p + 1 == n, 1'b0);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_pick e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_picks.size() == 0) begin
                report_mismatch($sformatf("unexpected pick slot %0d", o_pick_slot));
            end else begin
                e = pending_picks.pop_front();
                if (o_pick_slot !== e.slot || o_pick_score !== e.score
                        || o_last_pick !== e.last || o_empty_set !== e.empty)
                    report_mismatch($sformatf(
                        "got slot %0d score %0d last %b empty %b, want %0d %0d %b %b",
                        o_pick_slot, o_pick_score, o_last_pick, o_empty_set,
                        e.slot, e.score, e.last, e.empty));
            end
        end
    end

    // Sends one request; called right after a rising edge, returns at the accepting edge.
    task automatic send_item(input logic [1:0] op, input logic [4:0] cslot,
                             input logic [5:0] eslot, input logic [15:0] value,
                             input logic [5:0] count);
        while (!quiet && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_operation <= op;
        i_candidate_slot <= cslot;
        i_element_slot <= eslot;
        i_element_value <= value;
        i_candidate_count <= count;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (op == mmr_pkg::OP_LOAD_QUERY) query_mem[eslot] = value;
        else if (op == mmr_pkg::OP_LOAD_CAND) cand_mem[cslot][eslot] = value;
        else if (op == mmr_pkg::OP_RUN) predict_selection(count);
    endtask

    task automatic send_run(input logic [5:0] count);
        send_item(mmr_pkg::OP_RUN, 5'd0, 6'd0, 16'd0, count);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0 || o_in_stall) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == mmr_pkg::CFG_WEIGHT) weight_reg = data;
        else if (idx == mmr_pkg::CFG_MAX_PICKS) picks_reg = data[5:0];
        else if (idx == mmr_pkg::CFG_VEC_LEN) vlen_reg = data[6:0];
    endtask

    task automatic set_config(input logic [15:0] w, input logic [15:0] p,
                              input logic [15:0] l);
        wait_idle();
        write_reg(mmr_pkg::CFG_WEIGHT, w);
        write_reg(mmr_pkg::CFG_MAX_PICKS, p);
        write_reg(mmr_pkg::CFG_VEC_LEN, l);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // The leading elements of every vector are written first, and runs that read
    // vectors keep vector_length within them, so no run reads undefined memory.
    task automatic test_preload();
        for (int e = 0; e < PRE_DIM; e++)
            send_item(mmr_pkg::OP_LOAD_QUERY, 5'($urandom_range(31)), 6'(e), rand_value(),
                      6'($urandom_range(63)));
        for (int c = 0; c < NCAND; c++)
            for (int e = 0; e < PRE_DIM; e++)
                send_item(mmr_pkg::OP_LOAD_CAND, 5'(c), 6'(e), rand_value(),
                          6'($urandom_range(63)));
    endtask

    task automatic test_directed();
        // Reset weight and pick count first, then the special cases one by one.
        send_run(6'd0);
        send_item(2'd3, 5'd31, 6'd63, 16'hFFFF, 6'd63);
        wait_idle();
        write_reg(mmr_pkg::CFG_VEC_LEN, 16'd4);
        send_run(6'd4);
        set_config(16'd16384, 16'd4, 16'd4);
        send_item(mmr_pkg::OP_LOAD_QUERY, 5'd0, 6'd0, 16'h7FFF, 6'd0);
        send_item(mmr_pkg::OP_LOAD_QUERY, 5'd0, 6'd1, 16'h8000, 6'd0);
        send_item(mmr_pkg::OP_LOAD_CAND, 5'd0, 6'd0, 16'h7FFF, 6'd0);
        send_item(mmr_pkg::OP_LOAD_CAND, 5'd0, 6'd1, 16'h8000, 6'd0);
        for (int e = 0; e < 4; e++)
            send_item(mmr_pkg::OP_LOAD_CAND, 5'd1, 6'(e), 16'h0000, 6'd0);
        send_item(mmr_pkg::OP_LOAD_CAND, 5'd2, 6'd0, 16'h8001, 6'd0);
        send_item(mmr_pkg::OP_LOAD_CAND, 5'd2, 6'd1, 16'h7FFF, 6'd0);
        send_run(6'd5);
        set_config(16'd0, 16'd0, 16'd4);
        send_run(6'd3);
        set_config(16'd0, 16'd5, 16'hFFFF);
        send_run(6'd63);
        set_config(16'd32768, 16'd63, 16'd1);
        send_run(6'd5);
        set_config(16'hFFFF, 16'd32, 16'd0);
        send_run(6'd4);
        set_config(16'd1, 16'd2, 16'd4);
        send_run(6'd63);
        set_config(16'd32767, 16'd3, 16'd3);
        send_run(6'd2);
        wait_idle();
        write_reg(2'd3, 16'hFFFF);
    endtask

    task automatic test_random();
        int runs;
        int len;
        int src;
        for (int phase = 0; phase < 15; phase++) begin
            quiet = (phase >= 6 && phase < 9);
            case ($urandom_range(5))
                0: set_config(16'd0, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
                1: set_config(16'd32768, 16'($urandom_range(1, 8)),
                              16'($urandom_range(1, PRE_DIM)));
                2: set_config(16'hFFFF, 16'd1, 16'($urandom_range(1, PRE_DIM)));
                default: set_config(16'($urandom_range(32768)), 16'($urandom_range(1, 8)),
                                    16'($urandom_range(1, PRE_DIM)));
            endcase
            len = (vlen_reg > NDIM) ? NDIM : vlen_reg;
            runs = $urandom_range(1, 3);
            for (int r = 0; r < runs; r++) begin
                repeat ($urandom_range(1, 4)) begin
                    // Sometimes copy a vector, possibly negated, to force ties.
                    src = $urandom_range(31);
                    if ($urandom_range(3) == 0)
                        for (int e = 0; e < len && e < PRE_DIM; e++)
                            send_item(mmr_pkg::OP_LOAD_CAND, 5'($urandom_range(7)), 6'(e),
                                      ($urandom_range(1) ? -cand_mem[src][e]
                                                         : cand_mem[src][e]), 6'd0);
                    else
                        send_item(2'($urandom_range(1)), 5'($urandom_range(31)),
                                  6'($urandom_range(63)), rand_value(),
                                  6'($urandom_range(63)));
                end
                if ($urandom_range(24) == 0 && len <= 8)
                    send_item(mmr_pkg::OP_RUN, 5'($urandom_range(31)), 6'($urandom_range(63)),
                              16'($urandom_range(65535)), 6'($urandom_range(32, 63)));
                else if ($urandom_range(15) == 0)
                    send_run(6'd0);
                else
                    send_item(mmr_pkg::OP_RUN, 5'($urandom_range(31)), 6'($urandom_range(63)),
                              16'($urandom_range(65535)), 6'($urandom_range(1, 8)));
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        quiet = 1'b0;
        weight_reg = mmr_pkg::WEIGHT_RESET;
        picks_reg = mmr_pkg::MAX_PICKS_RESET;
        vlen_reg = mmr_pkg::VEC_LEN_RESET;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = mmr_pkg::OP_LOAD_QUERY;
        i_candidate_slot = '0;
        i_element_slot = '0;
        i_element_value = '0;
        i_candidate_count = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = mmr_pkg::CFG_WEIGHT;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_preload();
        test_directed();
        test_random();
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_picks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmr_pkg.sv
rtl/mmr_ram.sv
rtl/mmr_cos.sv
rtl/mmr_dp.sv
rtl/mmr_ctrl.sv
rtl/mmr_diverse_selector_top.sv
test/tb.sv
